### design/mhpq_pkg.sv
package mhpq_pkg;

  localparam int KEY_W    = 32;
  localparam int SYMBOL_W = 8;
  localparam int REF_W    = 9;
  localparam int CAP_W    = 9;
  localparam int COUNT_W  = 9;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_POPPED   = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [SYMBOL_W-1:0] symbol;
    logic [REF_W-1:0]    node_ref;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CHK,
    S_INS_CMP,
    S_POP_RD,
    S_POP_LOAD,
    S_DN_RD,
    S_DN_CMP,
    S_FINISH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic rd_parent;
    logic ins_cmp;
    logic wr_e;
    logic rd_pop;
    logic pop_load;
    logic rd_kids;
    logic dn_cmp;
    logic load_out;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_zero;
    logic parent_gt;
    logic no_left;
    logic dn_stop;
  } dp_sts_t;

endpackage

### design/mhpq_dpath.sv
module mhpq_dpath import mhpq_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [CAP_W-1:0]    cfg_data,
  input  logic                cmd,
  input  logic [KEY_W-1:0]    key,
  input  logic [SYMBOL_W-1:0] symbol,
  input  logic [REF_W-1:0]    node_ref,
  input  ctl_cmd_t            ctl,
  output dp_sts_t             sts,
  output logic [1:0]          status,
  output logic [KEY_W-1:0]    out_key,
  output logic [SYMBOL_W-1:0] out_symbol,
  output logic [REF_W-1:0]    out_node_ref,
  output logic [COUNT_W-1:0]  count
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int KW   = AW + 1;
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  logic [CAP_W-1:0]   capacity;
  logic [CW-1:0]      entry_count;
  logic [AW-1:0]      pos;
  entry_t             moving;
  status_t            res_status;
  entry_t             res_entry;
  status_t            out_status;
  entry_t             out_entry;
  logic [COUNT_W-1:0] out_count;

  entry_t             mem [DEPTH];
  entry_t             rd0;
  entry_t             rd1;

  logic               we;
  logic [AW-1:0]      wa;
  entry_t             wd;
  logic               re0;
  logic               re1;
  logic [AW-1:0]      ra0;
  logic [AW-1:0]      ra1;

  logic [AW-1:0]      parent;
  logic [KW-1:0]      left_idx;
  logic [KW-1:0]      right_idx;
  logic [KW-1:0]      n_ext;
  logic [CMPW-1:0]    cap_ext;
  logic [CMPW-1:0]    depth_ext;
  logic [CMPW-1:0]    limit;
  logic               full;
  logic               empty;
  logic               parent_gt;
  logic               use_l;
  logic               use_r;
  logic [KEY_W-1:0]   best_key;

  assign parent    = AW'(({1'b0, pos} - KW'(1)) >> 1);
  assign left_idx  = {pos, 1'b1};
  assign right_idx = {pos, 1'b0} + KW'(2);
  assign n_ext     = KW'(entry_count);

  assign cap_ext   = CMPW'(capacity);
  assign depth_ext = CMPW'(DEPTH);
  assign limit     = (cap_ext < depth_ext) ? cap_ext : depth_ext;
  assign full      = CMPW'(entry_count) >= limit;
  assign empty     = (entry_count == '0);

  assign parent_gt = rd0.key > moving.key;
  // left child first, right only if strictly below the better of the two
  assign use_l     = rd0.key < moving.key;
  assign best_key  = use_l ? rd0.key : moving.key;
  assign use_r     = (right_idx < n_ext) && (rd1.key < best_key);

  assign sts.full      = full;
  assign sts.empty     = empty;
  assign sts.pos_zero  = (pos == '0);
  assign sts.parent_gt = parent_gt;
  assign sts.no_left   = !(left_idx < n_ext);
  assign sts.dn_stop   = !use_l && !use_r;

  // the moving entry sits in a register; the hole it leaves is filled on the way
  always_comb begin
    we  = 1'b0;
    wa  = pos;
    wd  = moving;
    re0 = 1'b0;
    re1 = 1'b0;
    ra0 = '0;
    ra1 = '0;
    if (ctl.wr_e) begin
      we = 1'b1;
    end
    if (ctl.ins_cmp) begin
      we = 1'b1;
      wd = parent_gt ? rd0 : moving;
    end
    if (ctl.dn_cmp) begin
      we = 1'b1;
      wd = use_r ? rd1 : (use_l ? rd0 : moving);
    end
    if (ctl.rd_parent) begin
      re0 = 1'b1;
      ra0 = parent;
    end
    if (ctl.rd_pop) begin
      re0 = 1'b1;
      re1 = 1'b1;
      ra0 = '0;
      ra1 = AW'(entry_count - CW'(1));
    end
    if (ctl.rd_kids) begin
      re0 = 1'b1;
      re1 = 1'b1;
      ra0 = AW'(left_idx);
      ra1 = AW'(right_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re0) begin
      rd0 <= mem[ra0];
    end
    if (re1) begin
      rd1 <= mem[ra1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_write) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (ctl.accept && cmd == CMD_INSERT && !full) begin
      entry_count <= entry_count + CW'(1);
    end else if (ctl.pop_load) begin
      entry_count <= entry_count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      pos       <= AW'(entry_count);
      moving    <= {key, symbol, node_ref};
      res_entry <= '0;
      if (cmd == CMD_INSERT) begin
        res_status <= full ? ST_FULL : ST_INSERTED;
      end else begin
        res_status <= empty ? ST_EMPTY : ST_POPPED;
      end
    end
    if (ctl.ins_cmp && parent_gt) begin
      pos <= parent;
    end
    if (ctl.pop_load) begin
      pos       <= '0;
      moving    <= rd1;
      res_entry <= rd0;
    end
    if (ctl.dn_cmp) begin
      if (use_r) begin
        pos <= AW'(right_idx);
      end else if (use_l) begin
        pos <= AW'(left_idx);
      end
    end
    if (ctl.load_out) begin
      out_status <= res_status;
      out_entry  <= res_entry;
      out_count  <= COUNT_W'(entry_count);
    end
  end

  assign status       = out_status;
  assign out_key      = out_entry.key;
  assign out_symbol   = out_entry.symbol;
  assign out_node_ref = out_entry.node_ref;
  assign count        = out_count;

endmodule

### design/mhpq_ctrl.sv
module mhpq_ctrl import mhpq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     cmd,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_sts_t  sts,
  output ctl_cmd_t ctl
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (cmd == CMD_INSERT) begin
            state_next = sts.full ? S_FINISH : S_INS_CHK;
          end else begin
            state_next = sts.empty ? S_FINISH : S_POP_RD;
          end
        end
      end
      S_INS_CHK:  state_next = sts.pos_zero ? S_FINISH : S_INS_CMP;
      S_INS_CMP:  state_next = sts.parent_gt ? S_INS_CHK : S_FINISH;
      S_POP_RD:   state_next = S_POP_LOAD;
      S_POP_LOAD: state_next = S_DN_RD;
      S_DN_RD:    state_next = sts.no_left ? S_FINISH : S_DN_CMP;
      S_DN_CMP:   state_next = sts.dn_stop ? S_FINISH : S_DN_RD;
      S_FINISH:   state_next = out_free ? S_IDLE : S_FINISH;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        ctl.accept = in_valid;
      end
      S_INS_CHK: begin
        ctl.wr_e      = sts.pos_zero;
        ctl.rd_parent = !sts.pos_zero;
      end
      S_INS_CMP:  ctl.ins_cmp  = 1'b1;
      S_POP_RD:   ctl.rd_pop   = 1'b1;
      S_POP_LOAD: ctl.pop_load = 1'b1;
      S_DN_RD: begin
        ctl.wr_e    = sts.no_left;
        ctl.rd_kids = !sts.no_left;
      end
      S_DN_CMP:   ctl.dn_cmp   = 1'b1;
      S_FINISH:   ctl.load_out = out_free;
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (ctl.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### design/min_heap_priority_queue.sv
// Sequence, transfer in to result valid: a refused insert or a pop on empty goes straight to FINISH;
//   insert alternates INS_CHK and INS_CMP while the entry climbs, until it reaches the root or a parent not above it;
//   pop runs POP_RD and POP_LOAD, then DN_RD and DN_CMP while the moved entry sinks, until it stops or has no children.
//   The result then waits in FINISH on out_ready before it is loaded.
// Throughput: one item at a time; the next transfer in is taken the cycle after the result
//   is loaded.
// Reset: heap empty, capacity 256; entry memory contents undefined, no clearing pass.
module min_heap_priority_queue import mhpq_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                cmd,
  input  logic [KEY_W-1:0]    key,
  input  logic [SYMBOL_W-1:0] symbol,
  input  logic [REF_W-1:0]    node_ref,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          status,
  output logic [KEY_W-1:0]    out_key,
  output logic [SYMBOL_W-1:0] out_symbol,
  output logic [REF_W-1:0]    out_node_ref,
  output logic [COUNT_W-1:0]  count,
  input  logic                cfg_write,
  input  logic [CAP_W-1:0]    cfg_data
);

  ctl_cmd_t ctl;
  dp_sts_t  sts;

  mhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  mhpq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .key          (key),
    .symbol       (symbol),
    .node_ref     (node_ref),
    .ctl          (ctl),
    .sts          (sts),
    .status       (status),
    .out_key      (out_key),
    .out_symbol   (out_symbol),
    .out_node_ref (out_node_ref),
    .count        (count)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while an item is in flight");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result presented without an item in flight");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> count == '0 && out_key == '0)
    else $error("empty pop reports entries or a key");

  a_insert_no_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_INSERTED || status == ST_FULL)
    |-> out_key == '0 && out_symbol == '0 && out_node_ref == '0)
    else $error("insert result carries popped payload");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb import mhpq_pkg::*; ();

  localparam int HEAP_DEPTH = 256;
  localparam int WD_LIMIT   = 2000;

  typedef struct {
    logic                c;
    logic [KEY_W-1:0]    k;
    logic [SYMBOL_W-1:0] s;
    logic [REF_W-1:0]    r;
  } heap_op_t;

  typedef struct {
    status_t             st;
    logic [KEY_W-1:0]    k;
    logic [SYMBOL_W-1:0] s;
    logic [REF_W-1:0]    r;
    logic [COUNT_W-1:0]  n;
  } heap_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                cmd = CMD_INSERT;
  logic [KEY_W-1:0]    key = '0;
  logic [SYMBOL_W-1:0] symbol = '0;
  logic [REF_W-1:0]    node_ref = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          status;
  logic [KEY_W-1:0]    out_key;
  logic [SYMBOL_W-1:0] out_symbol;
  logic [REF_W-1:0]    out_node_ref;
  logic [COUNT_W-1:0]  count;
  logic                cfg_write = 1'b0;
  logic [CAP_W-1:0]    cfg_data = '0;

  min_heap_priority_queue #(.DEPTH(HEAP_DEPTH)) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .key          (key),
    .symbol       (symbol),
    .node_ref     (node_ref),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .out_key      (out_key),
    .out_symbol   (out_symbol),
    .out_node_ref (out_node_ref),
    .count        (count),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  heap_op_t     pending_ops[$];
  heap_result_t expected_results[$];
  heap_op_t     drv_op;
  int           snd_idle_pct = 0;
  int           rcv_idle_pct = 0;
  logic         in_taken = 1'b0;
  int           mismatch_count = 0;
  int           quiet_cycles = 0;

  // shadow heap
  entry_t           heap_mem [HEAP_DEPTH];
  int unsigned      heap_n = 0;
  logic [CAP_W-1:0] cap_reg = CAP_RESET;

  task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic void heap_swap(int unsigned a, int unsigned b);
    entry_t tmp;
    tmp = heap_mem[a];
    heap_mem[a] = heap_mem[b];
    heap_mem[b] = tmp;
  endfunction

  function automatic heap_result_t heap_apply(heap_op_t op);
    heap_result_t res;
    int unsigned  lim, pos, up, lc, rc, best;
    bit           done;
    res.st = ST_INSERTED;
    res.k = '0;
    res.s = '0;
    res.r = '0;
    lim = (cap_reg < HEAP_DEPTH) ? cap_reg : HEAP_DEPTH;
    if (op.c == CMD_INSERT) begin
      if (heap_n >= lim) begin
        res.st = ST_FULL;
      end else begin
        pos = heap_n;
        heap_mem[pos] = '{key: op.k, symbol: op.s, node_ref: op.r};
        heap_n++;
        done = 0;
        while (pos != 0 && !done) begin
          up = (pos - 1) / 2;
          if (heap_mem[up].key > heap_mem[pos].key) begin
            heap_swap(up, pos);
            pos = up;
          end else begin
            done = 1;
          end
        end
      end
    end else if (heap_n == 0) begin
      res.st = ST_EMPTY;
    end else begin
      res.st = ST_POPPED;
      res.k = heap_mem[0].key;
      res.s = heap_mem[0].symbol;
      res.r = heap_mem[0].node_ref;
      heap_n--;
      if (heap_n != 0) begin
        heap_mem[0] = heap_mem[heap_n];
        pos = 0;
        done = 0;
        while (!done) begin
          lc = 2 * pos + 1;
          rc = 2 * pos + 2;
          best = pos;
          // left child first; right only if strictly smaller still
          if (lc < heap_n && heap_mem[lc].key < heap_mem[best].key) best = lc;
          if (rc < heap_n && heap_mem[rc].key < heap_mem[best].key) best = rc;
          if (best == pos) begin
            done = 1;
          end else begin
            heap_swap(best, pos);
            pos = best;
          end
        end
      end
    end
    res.n = heap_n[COUNT_W-1:0];
    return res;
  endfunction

  task automatic check_result();
    heap_result_t want;
    if (expected_results.size() == 0) begin
      flag_mismatch("result with nothing outstanding", status, 0);
    end else begin
      want = expected_results.pop_front();
      if (status !== want.st)         flag_mismatch("status", status, want.st);
      if (out_key !== want.k)         flag_mismatch("out_key", out_key, want.k);
      if (out_symbol !== want.s)      flag_mismatch("out_symbol", out_symbol, want.s);
      if (out_node_ref !== want.r)    flag_mismatch("out_node_ref", out_node_ref, want.r);
      if (count !== want.n)           flag_mismatch("count", count, want.n);
    end
  endtask

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst) begin
      heap_n = 0;
      cap_reg = CAP_RESET;
      in_taken <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready)
        expected_results.push_back(heap_apply('{c: cmd, k: key, s: symbol, r: node_ref}));
      if (cfg_write) cap_reg = cfg_data;
      in_taken <= in_valid && in_ready;
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WD_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", WD_LIMIT);
        $display("tb failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // driver
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    if (!in_valid || in_taken) begin
      if (!rst && pending_ops.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        drv_op = pending_ops.pop_front();
        cmd      <= drv_op.c;
        key      <= drv_op.k;
        symbol   <= drv_op.s;
        node_ref <= drv_op.r;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic add_op(logic c, logic [KEY_W-1:0] k, logic [SYMBOL_W-1:0] s,
                        logic [REF_W-1:0] r);
    pending_ops.push_back('{c: c, k: k, s: s, r: r});
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(9))
      0:          pick_key = '0;
      1:          pick_key = '1;
      2, 3, 4, 5: pick_key = $urandom_range(15);   // plenty of ties
      6:          pick_key = 32'hFFFF_FFF0 | $urandom_range(15);
      default:    pick_key = $urandom;
    endcase
  endfunction

  task automatic add_random(int n, int ins_pct);
    for (int i = 0; i < n; i++)
      add_op(($urandom_range(99) < ins_pct) ? CMD_INSERT : CMD_POP, pick_key(),
             SYMBOL_W'($urandom_range(255)), REF_W'($urandom_range(511)));
  endtask

  task automatic wait_quiet();
    while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] v);
    wait_quiet();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_idling(int snd, int rcv);
    snd_idle_pct = snd;
    rcv_idle_pct = rcv;
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_idling(15, 68);

    // directed: extremes and ties at the reset capacity
    add_op(CMD_POP, '1, 8'hFF, 9'h1FF);
    add_op(CMD_INSERT, '1, 8'hFF, 9'h1FF);
    add_op(CMD_INSERT, '0, 8'h00, 9'h000);
    add_op(CMD_INSERT, 32'd5, 8'h01, 9'h0AA);
    add_op(CMD_INSERT, 32'd5, 8'h02, 9'h155);
    add_op(CMD_INSERT, 32'd5, 8'h03, 9'h001);
    repeat (6) add_op(CMD_POP, '0, 8'h00, 9'h000);
    // capacity of one
    set_capacity(9'd1);
    add_op(CMD_INSERT, 32'h8000_0000, 8'hA5, 9'h100);
    add_op(CMD_INSERT, 32'd1, 8'h5A, 9'h0FF);
    add_op(CMD_POP, '0, 8'h00, 9'h000);
    // capacity zero refuses everything
    set_capacity(9'd0);
    add_op(CMD_INSERT, 32'd7, 8'h11, 9'h011);
    add_op(CMD_POP, '0, 8'h00, 9'h000);
    // capacity lowered below the held count
    set_capacity(9'd256);
    repeat (4) add_op(CMD_INSERT, pick_key(), SYMBOL_W'($urandom_range(255)),
                      REF_W'($urandom_range(511)));
    set_capacity(9'd2);
    add_op(CMD_INSERT, 32'd9, 8'h22, 9'h022);
    add_op(CMD_POP, '0, 8'h00, 9'h000);
    add_op(CMD_POP, '0, 8'h00, 9'h000);
    add_op(CMD_INSERT, 32'd9, 8'h33, 9'h033);
    add_op(CMD_POP, '0, 8'h00, 9'h000);
    add_op(CMD_INSERT, 32'd9, 8'h44, 9'h044);

    // random: fill to the brim, then drain past empty
    set_capacity(9'd256);
    add_random(280, 100);
    add_random(300, 10);
    set_capacity(9'd7);
    add_random(300, 55);

    set_idling(68, 15);
    set_capacity(9'd511);   // above depth: depth is the limit
    add_random(270, 100);
    add_random(280, 5);

    set_idling(0, 0);
    set_capacity(9'd0);
    add_random(40, 50);
    set_capacity(9'd1);
    add_random(100, 50);
    set_capacity(9'd200);
    add_random(230, 100);
    set_capacity(9'd3);
    add_random(100, 40);

    wait_quiet();
    repeat (30) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

### sim.f
design/mhpq_pkg.sv
design/mhpq_dpath.sv
design/mhpq_ctrl.sv
design/min_heap_priority_queue.sv
tb/sv/tb.sv
